FILE: rtl/msp_pkg.sv
package msp_pkg;

    localparam int LENGTH_BITS  = 24;
    localparam int LEN_W1       = LENGTH_BITS + 1;
    localparam int SIZE_BITS    = 24;
    localparam int CMP_W        = ((LENGTH_BITS > SIZE_BITS) ? LENGTH_BITS : SIZE_BITS) + 1;

    localparam int HDR_BYTES    = 4;
    localparam int TINY_CLAUSE  = 12;
    localparam int FAT_CLAUSE   = 24;
    localparam int CLAUSE_BYTES = FAT_CLAUSE;
    localparam int CI_W         = 5;

    localparam int KIND_FAT_BIT  = 6;
    localparam int KIND_MORE_BIT = 7;
    localparam logic [7:0] KIND_MASK = 8'h3F;
    localparam logic [7:0] KIND_EH   = 8'h01;

    localparam logic REC_CLAUSE = 1'b0;
    localparam logic REC_END    = 1'b1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QP_W        = $clog2(QUEUE_DEPTH);
    localparam int QC_W        = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_ALIGN,
        MODE_HEADER,
        MODE_CLAUSE,
        MODE_SKIP
    } t_mode;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        area_start;
        logic [23:0] area_length;
        logic [1:0]  address_phase;
        logic        first_more_flag;
    } t_in;

    typedef struct packed {
        logic        record_kind;
        logic        clause_is_fat;
        logic [31:0] clause_flags;
        logic [31:0] try_start;
        logic [31:0] try_size;
        logic [31:0] handler_start;
        logic [31:0] handler_size;
        logic [31:0] extra_word;
    } t_out;

    typedef struct packed {
        logic [1:0] cnt;
        t_out       rec0;
        t_out       rec1;
    } t_push;

    typedef struct packed {
        logic            space_ok;
        logic [QC_W-1:0] count;
    } t_q_status;

endpackage

FILE: rtl/method_exception_section_parser_unit.sv
// Exception section parser: feed the bytes that follow a method body, one item per byte,
// marking the first byte of each area with area_start along with its length, address
// phase mod 4 and more-sections flag. Padding and section headers are consumed, each
// tiny (12 byte) or fat (24 byte) exception clause comes out as one record, and the list
// closes with an end record. One byte is taken every cycle unless stalled; a byte is
// registered, parsed in one pass, and its records land in a 4-entry output queue that
// drives the output. A byte that yields two records (a new area that closes at once
// while a list is open, or a last clause that also closes the list) uses a second queue
// slot; input stalls only while the queue holds more than two records.
module method_exception_section_parser_unit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  msp_pkg::t_in   i_data,
    output logic           o_valid,
    input  logic           i_stall,
    output msp_pkg::t_out  o_data
);
    import msp_pkg::*;

    t_push     w_push;
    t_q_status w_q_status;

    msp_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_data     (i_data),
        .i_q_status (w_q_status),
        .o_push     (w_push)
    );

    msp_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .o_q_status (w_q_status),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_data     (o_data)
    );

`ifndef SYNTHESIS
    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push.cnt != 2'd0 |-> $past(w_q_status.count) <= QC_W'(QUEUE_DEPTH))
        else $error("record pushed without queue room");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_status.count <= QC_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_push_gated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push.cnt != 2'd0 |-> w_q_status.space_ok)
        else $error("push while queue lacks two free slots");

    a_end_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.record_kind == REC_END |->
            o_data.clause_is_fat == 1'b0 && o_data.clause_flags == '0 &&
            o_data.try_start == '0 && o_data.try_size == '0 &&
            o_data.handler_start == '0 && o_data.handler_size == '0 &&
            o_data.extra_word == '0)
        else $error("end record carries clause data");
`endif

endmodule

FILE: rtl/msp_core.sv
module msp_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  msp_pkg::t_in         i_data,
    input  msp_pkg::t_q_status   i_q_status,
    output msp_pkg::t_push       o_push
);
    import msp_pkg::*;

    logic                   r_in_valid;
    t_in                    r_in;
    t_mode                  r_mode, n_mode;
    logic [LENGTH_BITS-1:0] r_bytes_left, n_bytes_left;
    logic [1:0]             r_addr_phase, n_addr_phase;
    logic                   r_more, n_more;
    logic [1:0]             r_hdr_idx, n_hdr_idx;
    logic [7:0]             r_sec_kind, n_sec_kind;
    logic [SIZE_BITS-1:0]   r_sec_size, n_sec_size;
    logic [SIZE_BITS-1:0]   r_sec_left, n_sec_left;
    logic [CI_W-1:0]        r_clause_idx, n_clause_idx;
    logic [7:0]             r_cb [CLAUSE_BYTES];
    logic                   n_cb_we;

    logic                   fire;
    logic                   f_abandon, f_clause, f_fat, f_end;
    logic [8*CLAUSE_BYTES-1:0] w_flat;

    function automatic t_mode sec_start(logic more, logic [1:0] ph,
                                        logic [LENGTH_BITS-1:0] bl);
        logic [1:0] adj;
        t_mode      m;
        adj = 2'd0 - ph;
        if (!more) begin
            m = MODE_IDLE;
        end else if (LEN_W1'(bl) < LEN_W1'(adj) + LEN_W1'(HDR_BYTES)) begin
            m = MODE_IDLE;
        end else if (adj != 2'd0) begin
            m = MODE_ALIGN;
        end else begin
            m = MODE_HEADER;
        end
        return m;
    endfunction

    assign fire    = r_in_valid && i_q_status.space_ok;
    assign o_stall = r_in_valid && !i_q_status.space_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_valid && !o_stall) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in <= i_data;
        end
    end

    always_comb begin : next_state
        logic done;
        logic fat;
        t_mode after;
        done         = 1'b0;
        fat          = 1'b0;
        after        = MODE_IDLE;
        n_mode       = r_mode;
        n_bytes_left = r_bytes_left;
        n_addr_phase = r_addr_phase;
        n_more       = r_more;
        n_hdr_idx    = r_hdr_idx;
        n_sec_kind   = r_sec_kind;
        n_sec_size   = r_sec_size;
        n_sec_left   = r_sec_left;
        n_clause_idx = r_clause_idx;
        n_cb_we      = 1'b0;
        f_abandon    = 1'b0;
        f_clause     = 1'b0;
        f_fat        = 1'b0;
        f_end        = 1'b0;
        if (fire) begin
            if (r_in.area_start) begin
                f_abandon    = (r_mode != MODE_IDLE);
                n_bytes_left = LENGTH_BITS'(r_in.area_length);
                n_addr_phase = r_in.address_phase;
                n_more       = r_in.first_more_flag;
                n_hdr_idx    = 2'd0;
                n_sec_kind   = '0;
                n_sec_size   = '0;
                n_sec_left   = '0;
                n_clause_idx = '0;
                n_mode = sec_start(r_in.first_more_flag, r_in.address_phase, n_bytes_left);
                if (n_mode == MODE_IDLE) begin
                    f_end = 1'b1;
                    done  = 1'b1;
                end
            end
            if (!done && n_mode != MODE_IDLE) begin
                if (n_bytes_left == '0) begin
                    n_mode = MODE_IDLE;
                    f_end  = 1'b1;
                end else begin
                    n_bytes_left = n_bytes_left - 1'b1;
                    n_addr_phase = n_addr_phase + 2'd1;
                    fat          = n_sec_kind[KIND_FAT_BIT];
                    case (n_mode)
                        MODE_ALIGN: begin
                            if (n_addr_phase == 2'd0) begin
                                n_mode    = MODE_HEADER;
                                n_hdr_idx = 2'd0;
                            end
                        end
                        MODE_HEADER: begin
                            case (n_hdr_idx)
                                2'd0: begin
                                    n_sec_kind = r_in.data_byte;
                                    n_sec_size = '0;
                                end
                                2'd1: begin
                                    n_sec_size = SIZE_BITS'(r_in.data_byte);
                                end
                                2'd2: begin
                                    if (n_sec_kind[KIND_FAT_BIT]) begin
                                        n_sec_size[15:8] = n_sec_size[15:8] | r_in.data_byte;
                                    end
                                end
                                default: begin
                                    if (n_sec_kind[KIND_FAT_BIT]) begin
                                        n_sec_size[23:16] = n_sec_size[23:16] | r_in.data_byte;
                                    end
                                end
                            endcase
                            if (n_hdr_idx == 2'd3) begin
                                n_hdr_idx = 2'd0;
                                n_more    = n_sec_kind[KIND_MORE_BIT];
                                if (n_sec_size < SIZE_BITS'(HDR_BYTES) ||
                                    CMP_W'(n_sec_size) >
                                    CMP_W'(n_bytes_left) + CMP_W'(HDR_BYTES)) begin
                                    n_mode = MODE_IDLE;
                                    f_end  = 1'b1;
                                end else begin
                                    n_sec_left   = n_sec_size - SIZE_BITS'(HDR_BYTES);
                                    n_clause_idx = '0;
                                    if (n_sec_left == '0) begin
                                        after  = sec_start(n_more, n_addr_phase, n_bytes_left);
                                        n_mode = after;
                                        f_end  = (after == MODE_IDLE);
                                    end else if ((n_sec_kind & KIND_MASK) == KIND_EH) begin
                                        n_mode = MODE_CLAUSE;
                                    end else begin
                                        n_mode = MODE_SKIP;
                                    end
                                end
                            end else begin
                                n_hdr_idx = n_hdr_idx + 2'd1;
                            end
                        end
                        MODE_CLAUSE: begin
                            n_cb_we      = (r_clause_idx < CI_W'(CLAUSE_BYTES));
                            n_clause_idx = n_clause_idx + 1'b1;
                            n_sec_left   = n_sec_left - 1'b1;
                            if (n_clause_idx == (fat ? CI_W'(FAT_CLAUSE) : CI_W'(TINY_CLAUSE)))
                            begin
                                f_clause     = 1'b1;
                                f_fat        = fat;
                                n_clause_idx = '0;
                            end
                            if (n_sec_left == '0) begin
                                after  = sec_start(n_more, n_addr_phase, n_bytes_left);
                                n_mode = after;
                                f_end  = (after == MODE_IDLE);
                            end
                        end
                        default: begin
                            n_sec_left = n_sec_left - 1'b1;
                            if (n_sec_left == '0) begin
                                after  = sec_start(n_more, n_addr_phase, n_bytes_left);
                                n_mode = after;
                                f_end  = (after == MODE_IDLE);
                            end
                        end
                    endcase
                end
            end
        end
    end

    always_comb begin : clause_view
        for (int i = 0; i < CLAUSE_BYTES; i++) begin
            w_flat[8*i +: 8] = (r_clause_idx == CI_W'(i)) ? r_in.data_byte : r_cb[i];
        end
    end

    always_comb begin : records
        t_out rec_end;
        t_out rec_cl;
        rec_end             = '0;
        rec_end.record_kind = REC_END;
        rec_cl               = '0;
        rec_cl.record_kind   = REC_CLAUSE;
        rec_cl.clause_is_fat = f_fat;
        if (f_fat) begin
            rec_cl.clause_flags  = w_flat[31:0];
            rec_cl.try_start     = w_flat[63:32];
            rec_cl.try_size      = w_flat[95:64];
            rec_cl.handler_start = w_flat[127:96];
            rec_cl.handler_size  = w_flat[159:128];
            rec_cl.extra_word    = w_flat[191:160];
        end else begin
            rec_cl.clause_flags  = 32'(w_flat[15:0]);
            rec_cl.try_start     = 32'(w_flat[31:16]);
            rec_cl.try_size      = 32'(w_flat[39:32]);
            rec_cl.handler_start = 32'(w_flat[55:40]);
            rec_cl.handler_size  = 32'(w_flat[63:56]);
            rec_cl.extra_word    = w_flat[95:64];
        end
        o_push.cnt  = 2'(f_abandon) + 2'(f_clause) + 2'(f_end);
        o_push.rec0 = f_abandon ? rec_end : (f_clause ? rec_cl : rec_end);
        o_push.rec1 = rec_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_IDLE;
            r_bytes_left <= '0;
            r_addr_phase <= '0;
            r_more       <= 1'b0;
            r_hdr_idx    <= '0;
            r_sec_kind   <= '0;
            r_sec_size   <= '0;
            r_sec_left   <= '0;
            r_clause_idx <= '0;
        end else begin
            r_mode       <= n_mode;
            r_bytes_left <= n_bytes_left;
            r_addr_phase <= n_addr_phase;
            r_more       <= n_more;
            r_hdr_idx    <= n_hdr_idx;
            r_sec_kind   <= n_sec_kind;
            r_sec_size   <= n_sec_size;
            r_sec_left   <= n_sec_left;
            r_clause_idx <= n_clause_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_cb_we) begin
            r_cb[r_clause_idx] <= r_in.data_byte;
        end
    end

endmodule

FILE: rtl/msp_queue.sv
module msp_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  msp_pkg::t_push       i_push,
    output msp_pkg::t_q_status   o_q_status,
    output logic                 o_valid,
    input  logic                 i_stall,
    output msp_pkg::t_out        o_data
);
    import msp_pkg::*;

    t_out            r_q [QUEUE_DEPTH];
    logic [QP_W-1:0] r_head, n_head;
    logic [QC_W-1:0] r_count, n_count;
    logic [QP_W-1:0] w_tail0, w_tail1;
    logic            w_pop;

    assign o_valid   = (r_count != '0);
    assign o_data    = r_q[r_head];
    assign w_pop     = o_valid && !i_stall;
    assign w_tail0   = r_head + r_count[QP_W-1:0];
    assign w_tail1   = w_tail0 + 1'b1;

    assign o_q_status.space_ok = (r_count <= QC_W'(QUEUE_DEPTH - 2));
    assign o_q_status.count    = r_count;

    always_comb begin
        n_head  = w_pop ? r_head + 1'b1 : r_head;
        n_count = r_count + QC_W'(i_push.cnt) - QC_W'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_q[w_tail0] <= i_push.rec0;
        end
        if (i_push.cnt == 2'd2) begin
            r_q[w_tail1] <= i_push.rec1;
        end
    end

endmodule

FILE: dv/tb_method_exception_section_parser_unit.sv
module tb_method_exception_section_parser_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import msp_pkg::*;

    localparam int RANDOM_ITEMS = 625;
    localparam int QUIET_LIMIT  = 4000;

    typedef struct {
        t_in item;
        int  n_end;
    } t_step_row;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_stall = 1'b0;
    t_in  i_data  = '0;
    logic o_stall;
    logic o_valid;
    t_out o_data;

    int   cur_typed    = -1;
    int   send_gap_pct = 26;
    int   stall_pct    = 65;
    int   mismatches   = 0;
    int   work_items   = 0;
    int   quiet_cycles = 0;
    t_out pending_records[$];

    t_mode       walk_mode     = MODE_IDLE;
    logic [23:0] area_left     = '0;
    logic [1:0]  addr_mod4     = '0;
    logic        more_sections = 1'b0;
    logic [1:0]  hdr_idx       = '0;
    logic [7:0]  sec_kind      = '0;
    logic [23:0] sec_size      = '0;
    logic [23:0] body_left     = '0;
    logic [4:0]  clause_pos    = '0;
    logic [7:0]  clause_buf [CLAUSE_BYTES];

    method_exception_section_parser_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    function automatic t_out end_record();
        t_out rec;
        rec = '0;
        rec.record_kind = REC_END;
        return rec;
    endfunction

    function automatic logic [31:0] le16(int at);
        return {16'd0, clause_buf[at + 1], clause_buf[at]};
    endfunction

    function automatic logic [31:0] le32(int at);
        return {clause_buf[at + 3], clause_buf[at + 2], clause_buf[at + 1], clause_buf[at]};
    endfunction

    function automatic bit open_section();
        logic [1:0] pad;
        if (!more_sections) begin
            walk_mode = MODE_IDLE;
            return 1'b1;
        end
        pad = 2'd0 - addr_mod4;
        if (pad > area_left || area_left - pad < HDR_BYTES) begin
            walk_mode = MODE_IDLE;
            return 1'b1;
        end
        walk_mode = (pad != 2'd0) ? MODE_ALIGN : MODE_HEADER;
        hdr_idx = '0;
        return 1'b0;
    endfunction

    function automatic bit close_header();
        more_sections = sec_kind[KIND_MORE_BIT];
        if (sec_size < HDR_BYTES || sec_size - HDR_BYTES > area_left) begin
            walk_mode = MODE_IDLE;
            return 1'b1;
        end
        body_left = sec_size - HDR_BYTES;
        clause_pos = '0;
        if (body_left == '0) begin
            return open_section();
        end
        walk_mode = ((sec_kind & KIND_MASK) == KIND_EH) ? MODE_CLAUSE : MODE_SKIP;
        return 1'b0;
    endfunction

    task automatic parse_byte(input t_in it, ref t_out made[$]);
        logic [7:0] b;
        logic       fat;
        bit         ended;
        t_out       rec;
        b = it.data_byte;
        made = {};
        ended = 1'b0;
        if (it.area_start) begin
            if (walk_mode != MODE_IDLE) begin
                made.push_back(end_record());
            end
            area_left = it.area_length;
            addr_mod4 = it.address_phase;
            more_sections = it.first_more_flag;
            hdr_idx = '0;
            sec_kind = '0;
            sec_size = '0;
            body_left = '0;
            clause_pos = '0;
            walk_mode = MODE_HEADER;
            if (open_section()) begin
                made.push_back(end_record());
                return;
            end
        end
        if (walk_mode == MODE_IDLE) begin
            return;
        end
        if (area_left == '0) begin
            walk_mode = MODE_IDLE;
            made.push_back(end_record());
            return;
        end
        area_left--;
        addr_mod4++;
        fat = sec_kind[KIND_FAT_BIT];
        case (walk_mode)
            MODE_ALIGN: begin
                if (addr_mod4 == 2'd0) begin
                    walk_mode = MODE_HEADER;
                    hdr_idx = '0;
                end
            end
            MODE_HEADER: begin
                if (hdr_idx == 2'd0) begin
                    sec_kind = b;
                    sec_size = '0;
                end else if (hdr_idx == 2'd1) begin
                    sec_size = {16'd0, b};
                end else if (sec_kind[KIND_FAT_BIT]) begin
                    sec_size[8 * (hdr_idx - 1) +: 8] = b;
                end
                if (hdr_idx == 2'd3) begin
                    hdr_idx = '0;
                    ended = close_header();
                end else begin
                    hdr_idx++;
                end
            end
            MODE_CLAUSE: begin
                if (clause_pos < CLAUSE_BYTES) begin
                    clause_buf[clause_pos] = b;
                end
                clause_pos++;
                body_left--;
                if (clause_pos == (fat ? FAT_CLAUSE : TINY_CLAUSE)) begin
                    rec = '0;
                    rec.record_kind = REC_CLAUSE;
                    rec.clause_is_fat = fat;
                    if (fat) begin
                        rec.clause_flags  = le32(0);
                        rec.try_start     = le32(4);
                        rec.try_size      = le32(8);
                        rec.handler_start = le32(12);
                        rec.handler_size  = le32(16);
                        rec.extra_word    = le32(20);
                    end else begin
                        rec.clause_flags  = le16(0);
                        rec.try_start     = le16(2);
                        rec.try_size      = {24'd0, clause_buf[4]};
                        rec.handler_start = le16(5);
                        rec.handler_size  = {24'd0, clause_buf[7]};
                        rec.extra_word    = le32(8);
                    end
                    made.push_back(rec);
                    clause_pos = '0;
                end
                if (body_left == '0) begin
                    ended = open_section();
                end
            end
            default: begin
                body_left--;
                if (body_left == '0) begin
                    ended = open_section();
                end
            end
        endcase
        if (ended) begin
            made.push_back(end_record());
        end
    endtask

    task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatches++;
        $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
    endtask

    always @(posedge i_clk) begin : watch
        t_out made[$];
        t_out want;
        bit   moved;
        if (i_rst_n) begin
            moved = 1'b0;
            if (i_valid && !o_stall) begin
                moved = 1'b1;
                parse_byte(i_data, made);
                work_items++;
                if (cur_typed >= 0) begin
                    made = {};
                    repeat (cur_typed) made.push_back(end_record());
                end
                foreach (made[k]) begin
                    pending_records.push_back(made[k]);
                end
            end
            if (o_valid && !i_stall) begin
                moved = 1'b1;
                if (pending_records.size() == 0) begin
                    flag_mismatch("record with none expected", {31'd0, o_data.record_kind}, '0);
                end else begin
                    want = pending_records.pop_front();
                    if (o_data.record_kind !== want.record_kind)
                        flag_mismatch("record_kind", {31'd0, o_data.record_kind},
                                      {31'd0, want.record_kind});
                    if (o_data.clause_is_fat !== want.clause_is_fat)
                        flag_mismatch("clause_is_fat", {31'd0, o_data.clause_is_fat},
                                      {31'd0, want.clause_is_fat});
                    if (o_data.clause_flags !== want.clause_flags)
                        flag_mismatch("clause_flags", o_data.clause_flags, want.clause_flags);
                    if (o_data.try_start !== want.try_start)
                        flag_mismatch("try_start", o_data.try_start, want.try_start);
                    if (o_data.try_size !== want.try_size)
                        flag_mismatch("try_size", o_data.try_size, want.try_size);
                    if (o_data.handler_start !== want.handler_start)
                        flag_mismatch("handler_start", o_data.handler_start, want.handler_start);
                    if (o_data.handler_size !== want.handler_size)
                        flag_mismatch("handler_size", o_data.handler_size, want.handler_size);
                    if (o_data.extra_word !== want.extra_word)
                        flag_mismatch("extra_word", o_data.extra_word, want.extra_word);
                end
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("[method_exception_section_parser_unit] ERROR");
                $finish;
            end
        end
    end

    function automatic t_in mk_item(logic [7:0] b, logic st, logic [23:0] len, logic [1:0] ph,
                                    logic mf);
        t_in it;
        it.data_byte = b;
        it.area_start = st;
        it.area_length = len;
        it.address_phase = ph;
        it.first_more_flag = mf;
        return it;
    endfunction

    function automatic logic [7:0] fill_byte();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0) return 8'hFF;
        if (r == 1) return 8'h00;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic t_in noise_item();
        logic [35:0] raw;
        t_in         it;
        raw = 36'({$urandom, $urandom});
        it = raw;
        it.area_start = 1'b0;
        return it;
    endfunction

    // enter and leave at a falling edge
    task automatic send_byte(t_in it, int n_end);
        while ($urandom_range(0, 99) < send_gap_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= it;
        cur_typed <= n_end;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
    endtask

    task automatic drain_records();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (pending_records.size() != 0) @(negedge i_clk);
    endtask

    task automatic make_area(ref logic [7:0] body[$], output logic [1:0] ph,
                             output logic more0, output logic [23:0] len);
        int          nsec;
        int          sel;
        int          nbody;
        int          csize;
        logic [1:0]  at;
        logic        fat;
        logic        last;
        logic [7:0]  kind;
        logic [23:0] size;
        body = {};
        ph = 2'($urandom_range(0, 3));
        more0 = ($urandom_range(0, 11) != 0);
        at = ph;
        nsec = more0 ? $urandom_range(1, 3) : 0;
        for (int s = 0; s < nsec; s++) begin
            while (at != 2'd0) begin
                body.push_back(fill_byte());
                at++;
            end
            sel = $urandom_range(0, 19);
            last = (s == nsec - 1);
            if (sel < 15) begin
                fat = (sel >= 9);
                csize = fat ? FAT_CLAUSE : TINY_CLAUSE;
                nbody = $urandom_range(0, 2) * csize;
                if ($urandom_range(0, 4) == 0) nbody += $urandom_range(1, csize - 1);
                kind = {~last, fat, 6'h01};
            end else begin
                fat = 1'($urandom_range(0, 1));
                nbody = $urandom_range(0, 30);
                kind = {~last, fat, 6'($urandom_range(2, 63))};
                if (sel == 19) kind = 8'($urandom_range(0, 255));
            end
            size = 24'(nbody + HDR_BYTES);
            if ($urandom_range(0, 24) == 0) size = 24'($urandom_range(0, 3));
            if (fat && $urandom_range(0, 29) == 0) size = 24'($urandom);
            body.push_back(kind);
            body.push_back(size[7:0]);
            body.push_back(kind[KIND_FAT_BIT] ? size[15:8] : fill_byte());
            body.push_back(kind[KIND_FAT_BIT] ? size[23:16] : fill_byte());
            repeat (nbody) body.push_back(fill_byte());
            at = at + 2'(nbody);
        end
        if (body.size() == 0) body.push_back(fill_byte());
        len = 24'(body.size());
        sel = $urandom_range(0, 19);
        if (sel < 2) begin
            len = 24'($urandom_range(0, body.size() - 1));
        end else if (sel == 2) begin
            len = 24'($urandom_range(body.size(), 24'hFFFFFF));
        end else if (sel == 3) begin
            body = body[0:$urandom_range(0, body.size() - 1)];
        end
    endtask

    initial begin : stimulus
        t_step_row   steps[$];
        logic [7:0]  body[$];
        logic [1:0]  ph;
        logic        more0;
        logic [23:0] len;
        t_in         it;
        int          base;
        int          done;

        // idle byte, clear more flag, zero length areas
        steps.push_back('{mk_item(8'hFF, 1'b0, 24'hFFFFFF, 2'd3, 1'b1), 0});
        steps.push_back('{mk_item(8'hFF, 1'b1, 24'hFFFFFF, 2'd3, 1'b0), 1});
        steps.push_back('{mk_item(8'h00, 1'b1, 24'd0, 2'd0, 1'b1), 1});
        steps.push_back('{mk_item(8'h00, 1'b1, 24'd0, 2'd2, 1'b1), 1});
        // padding, empty section with reserved bytes, then size under four
        steps.push_back('{mk_item(8'hAA, 1'b1, 24'd16, 2'd1, 1'b1), -1});
        steps.push_back('{mk_item(8'h55, 1'b0, 24'd0, 2'd0, 1'b0), -1});
        steps.push_back('{mk_item(8'hFF, 1'b0, 24'd0, 2'd0, 1'b0), -1});
        steps.push_back('{mk_item(8'h80, 1'b0, 24'd0, 2'd0, 1'b0), -1});
        steps.push_back('{mk_item(8'h04, 1'b0, 24'd0, 2'd0, 1'b0), -1});
        steps.push_back('{mk_item(8'hFF, 1'b0, 24'd0, 2'd0, 1'b0), -1});
        steps.push_back('{mk_item(8'hFF, 1'b0, 24'd0, 2'd0, 1'b0), -1});
        steps.push_back('{mk_item(8'h01, 1'b0, 24'd0, 2'd0, 1'b0), -1});
        steps.push_back('{mk_item(8'h02, 1'b0, 24'd0, 2'd0, 1'b0), -1});
        steps.push_back('{mk_item(8'hFF, 1'b0, 24'd0, 2'd0, 1'b0), -1});
        steps.push_back('{mk_item(8'hFF, 1'b0, 24'd0, 2'd0, 1'b0), -1});
        // section larger than the area
        steps.push_back('{mk_item(8'h01, 1'b1, 24'd8, 2'd0, 1'b1), -1});
        steps.push_back('{mk_item(8'hFF, 1'b0, 24'd0, 2'd0, 1'b0), -1});
        steps.push_back('{mk_item(8'h00, 1'b0, 24'd0, 2'd0, 1'b0), -1});
        steps.push_back('{mk_item(8'h00, 1'b0, 24'd0, 2'd0, 1'b0), -1});
        // new area while a fat clause is open
        steps.push_back('{mk_item(8'hC1, 1'b1, 24'd100, 2'd0, 1'b1), -1});
        steps.push_back('{mk_item(8'h1C, 1'b0, 24'd0, 2'd0, 1'b0), -1});
        steps.push_back('{mk_item(8'h00, 1'b0, 24'd0, 2'd0, 1'b0), -1});
        steps.push_back('{mk_item(8'h00, 1'b0, 24'd0, 2'd0, 1'b0), -1});
        steps.push_back('{mk_item(8'hFF, 1'b0, 24'd0, 2'd0, 1'b0), -1});
        steps.push_back('{mk_item(8'h00, 1'b1, 24'd0, 2'd0, 1'b0), 2});

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (steps[k]) begin
            send_byte(steps[k].item, steps[k].n_end);
        end
        drain_records();

        base = work_items;
        while (work_items - base < RANDOM_ITEMS) begin
            done = work_items - base;
            if (done < RANDOM_ITEMS / 3) begin
                send_gap_pct = 26;
                stall_pct = 65;
            end else if (done < 2 * RANDOM_ITEMS / 3) begin
                send_gap_pct = 65;
                stall_pct = 26;
            end else begin
                send_gap_pct = 0;
                stall_pct = 0;
            end
            make_area(body, ph, more0, len);
            foreach (body[k]) begin
                it = noise_item();
                it.data_byte = body[k];
                if (k == 0) begin
                    it.area_start = 1'b1;
                    it.area_length = len;
                    it.address_phase = ph;
                    it.first_more_flag = more0;
                end
                send_byte(it, -1);
            end
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 3)) send_byte(noise_item(), -1);
            end
            if ($urandom_range(0, 29) == 0) begin
                drain_records();
            end
        end

        i_valid <= 1'b0;
        while (pending_records.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (mismatches == 0 && pending_records.size() == 0) begin
            $display("[method_exception_section_parser_unit] OK");
        end else begin
            $display("[method_exception_section_parser_unit] ERROR");
        end
        $finish;
    end

endmodule

FILE: method_exception_section_parser_unit.f
rtl/msp_pkg.sv
rtl/msp_core.sv
rtl/msp_queue.sv
rtl/method_exception_section_parser_unit.sv
dv/tb_method_exception_section_parser_unit.sv
